@@ design/bmpunpk_pkg.sv @@
// shared types and constants for the bmp pixel stream unpacker
`default_nettype none

package bmpunpk_pkg;

	localparam int DEFAULT_MAX_WIDTH  = 4096;
	localparam int DEFAULT_MAX_HEIGHT = 4096;

	localparam logic [15:0] BMP_SIGNATURE    = 16'h4D42;
	localparam logic [15:0] DEPTH_24         = 16'd24;
	localparam logic [15:0] DEPTH_32         = 16'd32;
	localparam logic [31:0] HEADER_LAST_POS  = 32'd53;
	localparam logic [31:0] MIN_PIXEL_OFFSET = 32'd54;
	localparam logic [7:0]  ALPHA_OPAQUE     = 8'hFF;

	localparam int RESULT_FIFO_DEPTH = 8;
	localparam int RESULT_PTR_W      = $clog2(RESULT_FIFO_DEPTH);
	localparam int RESULT_CNT_W      = $clog2(RESULT_FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_HEADER = 2'd1,
		PH_DATA   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PIXEL  = 2'd0,
		KIND_HEADER = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_SIGNATURE = 3'd0,
		ERR_DEPTH     = 3'd1,
		ERR_SIZE      = 3'd2,
		ERR_TOO_LARGE = 3'd3,
		ERR_OFFSET    = 3'd4,
		ERR_TRUNCATED = 3'd5
	} err_t;

	typedef struct packed {
		kind_t       kind;
		err_t        error_code;
		logic [11:0] row;
		logic [11:0] column;
		logic [7:0]  chan_first;
		logic [7:0]  chan_second;
		logic [7:0]  chan_third;
		logic [7:0]  alpha;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic        last_pixel;
	} result_t;

endpackage

`default_nettype wire

@@ design/bmp_pixel_stream_unpacker_unit.sv @@
// bmp pixel stream unpacker: header parse and check, pixel unpacking, result queue
`default_nettype none

// Takes a 24- or 32-bit uncompressed bitmap file one byte per item (tuser marks the
// first byte, tlast the final byte) and produces a header result, then one result per
// pixel with its destination row and column, or an error result. One byte is taken
// every clock cycle while the queue has room: each byte is registered, decoded and its
// results (at most two) are written into an eight-entry result queue. Input stalls only
// when that queue lacks room for two results of the byte in flight, if any, and two of
// the next, i.e. when the downstream side holds off. Results are offered from the queue.
module bmp_pixel_stream_unpacker_unit
	import bmpunpk_pkg::*;
#(
	parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  wire logic        s_axis_tuser,  // [0] first_byte
	input  wire logic        s_axis_tlast,  // last_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [2:0] error_code, [14:3] row, [26:15] column, [34:27] chan_first,
	// [42:35] chan_second, [50:43] chan_third, [58:51] alpha,
	// [71:59] image_width, [84:72] image_height, [87:85] zero
	output logic [87:0]      m_axis_tdata,
	output logic [1:0]       m_axis_tuser,  // [1:0] kind
	output logic             m_axis_tlast   // last_pixel
);

	localparam int WB = $clog2(MAX_WIDTH + 1);
	localparam int HB = $clog2(MAX_HEIGHT + 1);
	localparam int RB = WB + 2;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       last_s1;

	// parser state
	phase_t      phase_q, phase_d;
	logic [31:0] pos_q, pos_d;
	logic [WB-1:0] col_q, col_d;
	logic [HB-1:0] row_q, row_d;
	logic [1:0]  bip_q, bip_d;
	logic [RB-1:0] rbc_q, rbc_d;
	logic [23:0] pix_q, pix_d;

	// captured header fields
	logic [15:0] sig_q;
	logic [31:0] offset_q;
	logic [31:0] rwid_q;
	logic [31:0] rhgt_q;
	logic [15:0] depth_q;

	// geometry fixed at header acceptance
	logic          is32_q;
	logic          neg_q;
	logic [WB-1:0] w_m1_q;
	logic [HB-1:0] h_m1_q;
	logic [RB-1:0] row_bytes_q;
	logic [RB-1:0] stride_q;

	// result queue
	result_t                 fifo_q [RESULT_FIFO_DEPTH];
	logic [RESULT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [RESULT_CNT_W-1:0] count_q;

	phase_t      ph_cur;
	logic [31:0] p;
	logic [31:0] habs;
	logic        chk_ok;
	err_t        chk_code;
	logic        cap_en;
	logic        load_geom;
	logic        fin;
	logic [1:0]  bpp_last;
	logic [RB-1:0] w3;
	logic [RB-1:0] rbc_inc;
	logic [HB-1:0] row_val;
	logic [HB+11:0] row_ext;
	logic [WB+11:0] col_ext;
	result_t     res0, res1;
	logic        res0_v, res1_v;
	logic        in_fire, out_fire;
	logic [RESULT_CNT_W:0] room_need;
	result_t     head;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	// keep room for both possible results of the byte in flight and of the next one
	assign room_need     = {1'b0, count_q} + (valid_s1 ? (RESULT_CNT_W+1)'(2) : '0);
	assign s_axis_tready = room_need <= (RESULT_CNT_W+1)'(RESULT_FIFO_DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1  <= s_axis_tdata;
			first_s1 <= s_axis_tuser;
			last_s1  <= s_axis_tlast;
		end
	end

	// a first byte restarts the parser at position zero
	assign ph_cur = first_s1 ? PH_HEADER : phase_q;
	assign p      = first_s1 ? '0 : pos_q;

	assign habs = rhgt_q[31] ? (~rhgt_q + 32'd1) : rhgt_q;

	always_comb begin
		chk_ok   = 1'b0;
		chk_code = ERR_SIGNATURE;
		priority if (sig_q != BMP_SIGNATURE) begin
			chk_code = ERR_SIGNATURE;
		end else if (depth_q != DEPTH_24 && depth_q != DEPTH_32) begin
			chk_code = ERR_DEPTH;
		end else if (rwid_q == '0 || rwid_q[31] || habs == '0) begin
			chk_code = ERR_SIZE;
		end else if (rwid_q > 32'(MAX_WIDTH) || habs > 32'(MAX_HEIGHT)) begin
			chk_code = ERR_TOO_LARGE;
		end else if (offset_q < MIN_PIXEL_OFFSET) begin
			chk_code = ERR_OFFSET;
		end else begin
			chk_ok = 1'b1;
		end
	end

	assign w3       = {rwid_q[WB-1:0], 1'b0} + RB'(rwid_q[WB-1:0]);
	assign bpp_last = is32_q ? 2'd3 : 2'd2;
	assign fin      = (row_q == h_m1_q) && (col_q == w_m1_q);
	assign rbc_inc  = rbc_q + RB'(1);
	assign row_val  = neg_q ? row_q : (h_m1_q - row_q);
	assign row_ext  = {12'b0, row_val};
	assign col_ext  = {12'b0, col_q};

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		col_d     = col_q;
		row_d     = row_q;
		bip_d     = bip_q;
		rbc_d     = rbc_q;
		pix_d     = pix_q;
		cap_en    = 1'b0;
		load_geom = 1'b0;
		res0      = '0;
		res1      = '0;
		res0_v    = 1'b0;
		res1_v    = 1'b0;
		if (valid_s1) begin
			phase_d = ph_cur;
			pos_d   = p;
			if (ph_cur != PH_IDLE) begin
				pos_d = (&p) ? p : p + 32'd1;
				if (ph_cur == PH_HEADER) begin
					cap_en = 1'b1;
					if (p >= HEADER_LAST_POS) begin
						res0_v = 1'b1;
						if (!chk_ok) begin
							res0.kind       = KIND_ERROR;
							res0.error_code = chk_code;
							phase_d         = PH_IDLE;
						end else begin
							res0.kind         = KIND_HEADER;
							res0.image_width  = rwid_q[12:0];
							res0.image_height = habs[12:0];
							load_geom         = 1'b1;
							phase_d           = PH_DATA;
							col_d             = '0;
							row_d             = '0;
							bip_d             = '0;
							rbc_d             = '0;
							pix_d             = '0;
						end
					end
				end else if (p >= offset_q) begin
					if (rbc_q < row_bytes_q) begin
						if (bip_q != bpp_last) begin
							unique case (bip_q)
								2'd0:    pix_d[7:0]   = byte_s1;
								2'd1:    pix_d[15:8]  = byte_s1;
								2'd2:    pix_d[23:16] = byte_s1;
								default: pix_d        = pix_q;
							endcase
							bip_d = bip_q + 2'd1;
						end else begin
							res0_v           = 1'b1;
							res0.kind        = KIND_PIXEL;
							res0.row         = row_ext[11:0];
							res0.column      = col_ext[11:0];
							res0.chan_first  = pix_q[7:0];
							res0.chan_second = pix_q[15:8];
							res0.chan_third  = is32_q ? pix_q[23:16] : byte_s1;
							res0.alpha       = is32_q ? byte_s1 : ALPHA_OPAQUE;
							res0.last_pixel  = fin;
							bip_d            = '0;
							pix_d            = '0;
							col_d            = col_q + WB'(1);
							if (fin) begin
								phase_d = PH_IDLE;
							end
						end
					end
					// row padding ends at the 32-bit stride
					if (rbc_inc == stride_q) begin
						rbc_d = '0;
						col_d = '0;
						row_d = row_q + HB'(1);
					end else begin
						rbc_d = rbc_inc;
					end
				end
				if (last_s1 && phase_d != PH_IDLE) begin
					phase_d = PH_IDLE;
					if (res0_v) begin
						res1_v          = 1'b1;
						res1.kind       = KIND_ERROR;
						res1.error_code = ERR_TRUNCATED;
					end else begin
						res0_v          = 1'b1;
						res0.kind       = KIND_ERROR;
						res0.error_code = ERR_TRUNCATED;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			bip_q   <= '0;
			rbc_q   <= '0;
			pix_q   <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			col_q   <= col_d;
			row_q   <= row_d;
			bip_q   <= bip_d;
			rbc_q   <= rbc_d;
			pix_q   <= pix_d;
		end
	end

	// header fields, little endian, at their fixed byte offsets
	always_ff @(posedge clk) begin
		if (cap_en && p[31:5] == '0) begin
			unique case (p[4:0])
				5'd0:    sig_q[7:0]      <= byte_s1;
				5'd1:    sig_q[15:8]     <= byte_s1;
				5'd10:   offset_q[7:0]   <= byte_s1;
				5'd11:   offset_q[15:8]  <= byte_s1;
				5'd12:   offset_q[23:16] <= byte_s1;
				5'd13:   offset_q[31:24] <= byte_s1;
				5'd18:   rwid_q[7:0]     <= byte_s1;
				5'd19:   rwid_q[15:8]    <= byte_s1;
				5'd20:   rwid_q[23:16]   <= byte_s1;
				5'd21:   rwid_q[31:24]   <= byte_s1;
				5'd22:   rhgt_q[7:0]     <= byte_s1;
				5'd23:   rhgt_q[15:8]    <= byte_s1;
				5'd24:   rhgt_q[23:16]   <= byte_s1;
				5'd25:   rhgt_q[31:24]   <= byte_s1;
				5'd28:   depth_q[7:0]    <= byte_s1;
				5'd29:   depth_q[15:8]   <= byte_s1;
				default: sig_q           <= sig_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_geom) begin
			is32_q <= depth_q[5];
			neg_q  <= rhgt_q[31];
			w_m1_q <= rwid_q[WB-1:0] - WB'(1);
			h_m1_q <= habs[HB-1:0] - HB'(1);
			if (depth_q[5]) begin
				row_bytes_q <= {rwid_q[WB-1:0], 2'b00};
				stride_q    <= {rwid_q[WB-1:0], 2'b00};
			end else begin
				row_bytes_q <= w3;
				stride_q    <= (w3 + RB'(3)) & ~RB'(3);
			end
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (res0_v) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (res1_v) begin
			fifo_q[wr_ptr_q + RESULT_PTR_W'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RESULT_PTR_W'(res0_v) + RESULT_PTR_W'(res1_v);
			rd_ptr_q <= rd_ptr_q + RESULT_PTR_W'(out_fire);
			count_q  <= count_q + RESULT_CNT_W'(res0_v) + RESULT_CNT_W'(res1_v)
			            - RESULT_CNT_W'(out_fire);
		end
	end

	assign head          = fifo_q[rd_ptr_q];
	assign m_axis_tvalid = count_q != '0;
	assign m_axis_tuser  = head.kind;
	assign m_axis_tlast  = head.last_pixel;
	assign m_axis_tdata  = {3'b000, head.image_height, head.image_width, head.alpha,
	                        head.chan_third, head.chan_second, head.chan_first,
	                        head.column, head.row, head.error_code};

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= RESULT_CNT_W'(RESULT_FIFO_DEPTH))
		else $error("result queue overfilled");

	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (room_need <= (RESULT_CNT_W+1)'(RESULT_FIFO_DEPTH - 2)))
		else $error("byte taken without room for its results");

	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		res1_v |-> (res0_v && res1.kind == KIND_ERROR && res1.error_code == ERR_TRUNCATED))
		else $error("second result without a first one");

	a_pixel_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		(res0_v && res0.kind == KIND_PIXEL) |-> (ph_cur == PH_DATA && valid_s1))
		else $error("pixel produced outside the pixel data");

	a_final_pixel_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(res0_v && res0.kind == KIND_PIXEL && res0.last_pixel) |=> (phase_q == PH_IDLE))
		else $error("parser still busy after the final pixel");

endmodule

`default_nettype wire
